// ===== sv/tbm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults for the thresholded 3x3 binary morphology block.
package tbm_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// APB register map, one 32-bit word per register
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_MODE      = 2'd1,
		REG_WIDTH     = 2'd2,
		REG_HEIGHT    = 2'd3
	} reg_idx_t;

	localparam logic [1:0] MODE_BINARIZE = 2'd0;
	localparam logic [1:0] MODE_DILATE   = 2'd1;
	localparam logic [1:0] MODE_ERODE    = 2'd2;

	localparam logic [7:0]  RST_THRESHOLD = 8'd128;
	localparam logic [1:0]  RST_MODE      = MODE_DILATE;
	localparam logic [10:0] RST_WIDTH     = 11'd640;
	localparam logic [12:0] RST_HEIGHT    = 13'd480;

	localparam logic [7:0] PIX_WHITE = 8'd255;
	localparam logic [7:0] PIX_BLACK = 8'd0;

	// result buffer
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// per-pixel info worked out at input time, consumed in the window stage
	typedef struct packed {
		logic cur;       // thresholded pixel
		logic emit;      // this transfer yields a result
		logic fe;        // result is the last pixel of the frame
		logic sel_old;   // centre is last column of an earlier row: use window before shift
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
	} pos_t;

	typedef struct packed {
		logic pix;
		logic fe;
	} res_t;

endpackage

// ===== sv/threshold_binary_morphology_3x3.sv =====
`timescale 1ns / 1ps
// Top level: thresholded binary 3x3 dilation / erosion on a raster pixel stream.
//
// Gray pixels arrive in raster order, are thresholded (at or above threshold is
// white) and leave as 0 or 255: the binary pixel itself (mode 0 or 3), its 3x3
// dilation (mode 1) or its 3x3 erosion (mode 2); the window is clipped at the
// image borders. One pixel per clock is accepted and one result per clock is
// delivered when not stalled. Each result trails its input by one line plus one
// pixel, so a frame of W x H needs W+1 pad transfers after its last pixel to
// flush; frame_end marks the result of the last pixel, after which the next
// transfer starts a new frame. The two previous binary lines live in one
// synchronous 2-bit x MAX_WIDTH memory, read when a pixel is taken and written
// back in the next cycle, with a bypass for one-pixel-wide frames; its contents
// start undefined and need no clearing pass, since an unwritten entry only
// reaches window positions outside the image. Each pixel is registered in the
// window stage, its result in the buffer. in_stall comes from registers only:
// it rises when the three-entry result buffer plus the item in the window stage
// could overfill it. Configure only while idle; writing frame_width or
// frame_height restarts the frame. Width 0 acts as 1, over MAX_WIDTH as
// MAX_WIDTH (likewise for height).
module threshold_binary_morphology_3x3 #(
	parameter int MAX_WIDTH  = tbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tbm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tbm_pkg::ADDR_W-1:0] paddr,
	input  logic [tbm_pkg::DATA_W-1:0] pwdata,
	output logic [tbm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// pixel input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 gray_pixel,
	input  logic                       pad,
	// result output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_pixel,
	output logic                       frame_end
);
	import tbm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);        // column index
	localparam int WW = $clog2(MAX_WIDTH + 1);    // effective width
	localparam int HW = $clog2(MAX_HEIGHT + 1);   // effective height
	localparam int RW = $clog2(MAX_HEIGHT + 2);   // row count runs to height+1 during flush

	// ---------------- configuration registers ----------------
	logic [7:0]  threshold_q;
	logic [1:0]  mode_q;
	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        cfg_wr;
	logic        restart;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign restart = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= RST_THRESHOLD;
			mode_q         <= RST_MODE;
			frame_width_q  <= RST_WIDTH;
			frame_height_q <= RST_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_THRESHOLD: threshold_q    <= pwdata[7:0];
				REG_MODE:      mode_q         <= pwdata[1:0];
				REG_WIDTH:     frame_width_q  <= pwdata[10:0];
				REG_HEIGHT:    frame_height_q <= pwdata[12:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			REG_MODE:      prdata = DATA_W'(mode_q);
			REG_WIDTH:     prdata = DATA_W'(frame_width_q);
			REG_HEIGHT:    prdata = DATA_W'(frame_height_q);
			default:       prdata = '0;
		endcase
	end

	// clamped geometry
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
	end

	// ---------------- input side: raster position and border flags ----------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          in_acc;
	logic          col0, last_col;
	logic [RW-1:0] h_row, h_row_p1;
	pos_t          pos;

	assign in_acc   = in_valid && !in_stall;
	assign col0     = (col_q == '0);
	assign last_col = ((WW'(col_q) + WW'(1)) == w_eff);
	assign h_row    = RW'(h_eff);
	assign h_row_p1 = h_row + RW'(1);

	always_comb begin
		pos.cur     = !pad && (gray_pixel >= threshold_q);
		pos.emit    = (row_q >= RW'(1)) && (!col0 || (row_q >= RW'(2)));
		pos.fe      = pos.emit && col0 && (row_q == h_row_p1);
		pos.sel_old = col0;
		if (col0) begin
			// centre is the last pixel of the row two above
			pos.left_ok  = (w_eff > WW'(1));
			pos.right_ok = 1'b0;
			pos.top_ok   = (row_q > RW'(2));
			pos.bot_ok   = (row_q <= h_row);
		end else begin
			// centre is one column left, one row up
			pos.left_ok  = (col_q >= CW'(2));
			pos.right_ok = 1'b1;
			pos.top_ok   = (row_q >= RW'(2));
			pos.bot_ok   = (row_q < h_row);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (pos.fe) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- line store + window stage ----------------
	logic busy;
	logic push;
	res_t res;

	tbm_line_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.col     (col_q),
		.pos     (pos),
		.restart (restart),
		.mode    (mode_q),
		.busy    (busy),
		.push    (push),
		.res     (res)
	);

	// ---------------- result buffer and output channel ----------------
	logic                  pop;
	res_t                  head;
	logic [FIFO_CNT_W-1:0] fifo_count;

	assign pop = out_valid && !out_stall;

	tbm_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (res),
		.pop      (pop),
		.valid    (out_valid),
		.head     (head),
		.count    (fifo_count)
	);

	assign out_pixel = head.pix ? PIX_WHITE : PIX_BLACK;
	assign frame_end = head.fe;

	// buffered results plus the one in flight must leave room for the next transfer
	assign in_stall = (({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(busy))
	                  >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));

	// ---------------- assertions ----------------
	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((fifo_count < FIFO_CNT_W'(FIFO_DEPTH)) || pop))
		else $error("result buffer overflow");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pos.fe && !restart) |=> ((col_q == '0) && (row_q == '0)))
		else $error("raster position not cleared after frame end");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_row_p1)
		else $error("row count ran past the flush row");

endmodule

// ===== sv/tbm_line_window.sv =====
`timescale 1ns / 1ps
// Line store memory, 3x3 window register and morphology evaluation.
module tbm_line_window #(
	parameter int MAX_WIDTH = tbm_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  tbm_pkg::pos_t                pos,
	input  logic                         restart,
	input  logic [1:0]                   mode,
	output logic                         busy,
	output logic                         push,
	output tbm_pkg::res_t                res
);
	import tbm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	// entry = {lower row bit, upper row bit}
	logic [1:0]    line_mem [MAX_WIDTH];
	logic [1:0]    rd_s1;
	logic [CW-1:0] col_s1;
	pos_t          pos_s1;
	logic          v_s1;
	logic [8:0]    win_q;

	logic [2:0] new_col;
	logic [8:0] win_new;
	logic [1:0] wr_data;
	logic [2:0] lcol, ccol, rcol;
	logic [2:0] rowmask, lmask, rmask;
	logic [8:0] bits, present;
	logic       pix;

	// column stack: bit 0 upper, bit 1 centre, bit 2 lower (newest)
	assign new_col = {pos_s1.cur, rd_s1[1], rd_s1[0]};
	assign win_new = {new_col, win_q[8:3]};
	assign wr_data = {pos_s1.cur, rd_s1[1]};

	// read at input transfer, write back in the following cycle; forward on same column
	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[col_s1] <= wr_data;
		end
		if (accept) begin
			if (v_s1 && (col_s1 == col)) begin
				rd_s1 <= wr_data;
			end else begin
				rd_s1 <= line_mem[col];
			end
			col_s1 <= col;
			pos_s1 <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			win_q <= '0;
		end else begin
			v_s1 <= accept;
			if (restart) begin
				win_q <= '0;
			end else if (v_s1) begin
				win_q <= pos_s1.fe ? '0 : win_new;
			end
		end
	end

	always_comb begin
		if (pos_s1.sel_old) begin
			lcol = win_q[5:3];
			ccol = win_q[8:6];
			rcol = '0;
		end else begin
			lcol = win_new[2:0];
			ccol = win_new[5:3];
			rcol = win_new[8:6];
		end
		rowmask = {pos_s1.bot_ok, 1'b1, pos_s1.top_ok};
		lmask   = pos_s1.left_ok  ? rowmask : 3'b000;
		rmask   = pos_s1.right_ok ? rowmask : 3'b000;
		bits    = {rcol & rmask, ccol & rowmask, lcol & lmask};
		present = {rmask, rowmask, lmask};
		case (mode)
			MODE_DILATE: pix = |bits;
			MODE_ERODE:  pix = (bits == present);
			default:     pix = ccol[1];
		endcase
	end

	assign busy = v_s1;
	assign push = v_s1 && pos_s1.emit;
	assign res  = '{pix: pix, fe: pos_s1.fe};

endmodule

// ===== sv/tbm_out_fifo.sv =====
`timescale 1ns / 1ps
// Three-entry result buffer between the window stage and the output channel.
module tbm_out_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  tbm_pkg::res_t                      push_res,
	input  logic                               pop,
	output logic                               valid,
	output tbm_pkg::res_t                      head,
	output logic [tbm_pkg::FIFO_CNT_W-1:0]     count
);
	import tbm_pkg::*;

	res_t                  fifo_mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	assign valid = (count_q != '0);
	assign head  = fifo_mem[rd_ptr_q];
	assign count = count_q;

endmodule
